// File: hdl/mm4_pkg.sv
// mm4_pkg: shared types, codes and defaults for the 4x4 matrix multiply core.
// Depends on nothing; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps

package mm4_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;

   localparam int IDX_W = 2;                // row, column and k index width
   localparam int ADDR_W = 2 * IDX_W;       // store address {row, col}
   localparam int SEQ_W = 3 * IDX_W;        // compute step {row, col, k}
   localparam logic [SEQ_W-1:0] SEQ_LAST = '1;
   localparam logic [IDX_W-1:0] IDX_LAST = '1;

   typedef enum logic [1:0] {
      REQ_WR_LEFT  = 2'd0,
      REQ_WR_RIGHT = 2'd1,
      REQ_COMPUTE  = 2'd2
   } req_code_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      logic              wr_left;
      logic              wr_right;
      logic [ADDR_W-1:0] wr_addr;
      logic              issue;
      logic [SEQ_W-1:0]  seq;
   } cmd_type;

   typedef struct packed {
      logic advance;
   } status_type;

endpackage

// File: hdl/mm4_if.sv
// mm4_req_if, mm4_rsp_if: valid/ready channels of the matrix multiply core.
// Depends on mm4_pkg for the index width and the default data width.
`timescale 1ns / 1ps

interface mm4_req_if #(
   parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEFAULT
);
   logic                             valid;
   logic                             ready;
   logic [1:0]                       req_type;
   logic [mm4_pkg::IDX_W-1:0]        row;
   logic [mm4_pkg::IDX_W-1:0]        col;
   logic signed [DATA_WIDTH-1:0]     value;

   modport source (output valid, req_type, row, col, value, input ready);
   modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

interface mm4_rsp_if #(
   parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEFAULT
);
   logic                             valid;
   logic                             ready;
   logic [mm4_pkg::IDX_W-1:0]        out_row;
   logic [mm4_pkg::IDX_W-1:0]        out_col;
   logic signed [DATA_WIDTH-1:0]     product;
   logic                             saturated;
   logic                             last;

   modport source (output valid, out_row, out_col, product, saturated, last, input ready);
   modport sink   (input valid, out_row, out_col, product, saturated, last, output ready);
endinterface

// File: hdl/mm4_ctrl.sv
// mm4_ctrl: request decode and compute sequencer of the matrix multiply core.
// Depends on mm4_pkg for the state, request codes and command/status structs.
`timescale 1ns / 1ps

module mm4_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [1:0]                    req_type,
   input  logic [mm4_pkg::IDX_W-1:0]     req_row,
   input  logic [mm4_pkg::IDX_W-1:0]     req_col,
   output logic                          req_ready,
   output mm4_pkg::cmd_type              cmd,
   input  mm4_pkg::status_type           status
);

   mm4_pkg::state_type              state_ff, state_in;
   logic [mm4_pkg::SEQ_W-1:0]       seq_ff, seq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm4_pkg::ST_IDLE;
         seq_ff   <= '0;
      end else begin
         state_ff <= state_in;
         seq_ff   <= seq_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      seq_in        = seq_ff;
      req_ready     = 1'b0;
      cmd.wr_left   = 1'b0;
      cmd.wr_right  = 1'b0;
      cmd.wr_addr   = {req_row, req_col};
      cmd.issue     = 1'b0;
      cmd.seq       = seq_ff;
      case (state_ff)
         mm4_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_type)
                  mm4_pkg::REQ_WR_LEFT:  cmd.wr_left  = 1'b1;
                  mm4_pkg::REQ_WR_RIGHT: cmd.wr_right = 1'b1;
                  mm4_pkg::REQ_COMPUTE: begin
                     state_in = mm4_pkg::ST_RUN;
                     seq_in   = '0;
                  end
                  default: ;
               endcase
            end
         end
         mm4_pkg::ST_RUN: begin
            if (status.advance) begin
               cmd.issue = 1'b1;
               seq_in    = seq_ff + 1'b1;
               if (seq_ff == mm4_pkg::SEQ_LAST) begin
                  state_in = mm4_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = mm4_pkg::ST_IDLE;
      endcase
   end

endmodule

// File: hdl/mm4_datapath.sv
// mm4_datapath: element stores, split multiplier, accumulator, saturation, result register.
// Depends on mm4_pkg for the command/status structs and index widths.
`timescale 1ns / 1ps

module mm4_datapath #(
   parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mm4_pkg::cmd_type              cmd,
   input  logic [DATA_WIDTH-1:0]         wr_value,
   output mm4_pkg::status_type           status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [mm4_pkg::IDX_W-1:0]     rsp_row,
   output logic [mm4_pkg::IDX_W-1:0]     rsp_col,
   output logic [DATA_WIDTH-1:0]         rsp_product,
   output logic                          rsp_saturated,
   output logic                          rsp_last
);

   localparam int LO    = DATA_WIDTH / 2;
   localparam int HI    = DATA_WIDTH - LO;
   localparam int WIDE  = 2 * DATA_WIDTH;
   localparam int EXT_W = WIDE + FRAC_BITS;
   localparam int SUM_W = WIDE + 2;
   localparam int IW    = mm4_pkg::IDX_W;
   localparam int SW    = mm4_pkg::SEQ_W;
   localparam int DEPTH = 1 << mm4_pkg::ADDR_W;

   logic [DATA_WIDTH-1:0] left_mem  [DEPTH];
   logic [DATA_WIDTH-1:0] right_mem [DEPTH];

   logic                  adv;

   // read stage
   logic                  v0_ff;
   logic [SW-1:0]         seq0_ff;
   logic [DATA_WIDTH-1:0] a_ff, b_ff;

   // partial product stage
   logic                  v1_ff;
   logic [SW-1:0]         seq1_ff;
   logic signed [2*HI-1:0]  pp_hh_ff, pp_hh_in;
   logic signed [HI+LO:0]   pp_hl_ff, pp_hl_in;
   logic signed [HI+LO:0]   pp_lh_ff, pp_lh_in;
   logic [2*LO-1:0]         pp_ll_ff, pp_ll_in;

   // shifted term stage
   logic                  v2_ff;
   logic [SW-1:0]         seq2_ff;
   logic [WIDE-1:0]       full;
   logic signed [EXT_W-1:0] ext;
   logic signed [WIDE-1:0] term_ff, term_in;

   // accumulate stage
   logic                  v3_ff;
   logic [SW-1:0]         seq3_ff;
   logic signed [SUM_W-1:0] acc_ff, acc_in;

   // result register
   logic                  rsp_valid_ff;
   logic [SW-1:0]         rsp_seq_ff;
   logic [DATA_WIDTH-1:0] product_ff, product_in;
   logic                  sat_ff, sat_in;
   logic [SUM_W-DATA_WIDTH:0] acc_top;

   assign adv            = !rsp_valid_ff || rsp_ready;
   assign status.advance = adv;

   always_ff @(posedge clock) begin
      if (cmd.wr_left) begin
         left_mem[cmd.wr_addr] <= wr_value;
      end
      if (cmd.wr_right) begin
         right_mem[cmd.wr_addr] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         a_ff <= left_mem[{cmd.seq[SW-1 -: IW], cmd.seq[IW-1:0]}];
         b_ff <= right_mem[{cmd.seq[IW-1:0], cmd.seq[2*IW-1 -: IW]}];
      end
   end

   always_comb begin
      pp_hh_in = $signed(a_ff[DATA_WIDTH-1:LO]) * $signed(b_ff[DATA_WIDTH-1:LO]);
      pp_hl_in = $signed(a_ff[DATA_WIDTH-1:LO]) * $signed({1'b0, b_ff[LO-1:0]});
      pp_lh_in = $signed({1'b0, a_ff[LO-1:0]}) * $signed(b_ff[DATA_WIDTH-1:LO]);
      pp_ll_in = a_ff[LO-1:0] * b_ff[LO-1:0];
   end

   always_comb begin
      full = (WIDE'(pp_hh_ff) << (2 * LO)) + (WIDE'(pp_hl_ff) << LO)
           + (WIDE'(pp_lh_ff) << LO) + WIDE'(pp_ll_ff);
      ext     = EXT_W'($signed(full));
      term_in = ext[EXT_W-1:FRAC_BITS];
   end

   always_comb begin
      if (seq2_ff[IW-1:0] == '0) begin
         acc_in = SUM_W'(term_ff);
      end else begin
         acc_in = acc_ff + SUM_W'(term_ff);
      end
   end

   always_comb begin
      acc_top = acc_ff[SUM_W-1:DATA_WIDTH-1];
      if ((&acc_top) || !(|acc_top)) begin
         product_in = acc_ff[DATA_WIDTH-1:0];
         sat_in     = 1'b0;
      end else begin
         product_in = {acc_ff[SUM_W-1], {(DATA_WIDTH-1){!acc_ff[SUM_W-1]}}};
         sat_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff        <= cmd.issue;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff && (seq2_ff[IW-1:0] == mm4_pkg::IDX_LAST);
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seq0_ff  <= cmd.seq;
         seq1_ff  <= seq0_ff;
         pp_hh_ff <= pp_hh_in;
         pp_hl_ff <= pp_hl_in;
         pp_lh_ff <= pp_lh_in;
         pp_ll_ff <= pp_ll_in;
         seq2_ff  <= seq1_ff;
         term_ff  <= term_in;
         if (v2_ff) begin
            seq3_ff <= seq2_ff;
            acc_ff  <= acc_in;
         end
         if (v3_ff) begin
            rsp_seq_ff <= seq3_ff;
            product_ff <= product_in;
            sat_ff     <= sat_in;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row       = rsp_seq_ff[SW-1 -: IW];
   assign rsp_col       = rsp_seq_ff[2*IW-1 -: IW];
   assign rsp_product   = product_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_last      = (rsp_seq_ff[SW-1:IW] == '1);

endmodule

// File: hdl/matrix4x4_multiply_core.sv
// matrix4x4_multiply_core: 4x4 signed fixed-point matrix product, left times right.
// Depends on mm4_pkg, mm4_req_if/mm4_rsp_if, mm4_ctrl and mm4_datapath.
//
//   channel   dir   handshake              payload
//   req_ch    in    req_ch.valid/ready     req_type, row, col, value
//   rsp_ch    out   rsp_ch.valid/ready     out_row, out_col, product, saturated, last
//
// A compute request runs the shared multiplier over 64 steps, one left*right term per
// cycle while no held result stalls the pipeline, to give the sixteen results. Stores
// hold no reset value; reset clears the sequencer and pipeline valids only. A held
// result freezes the whole pipeline until it is taken.
`timescale 1ns / 1ps

module matrix4x4_multiply_core #(
   parameter int DATA_WIDTH = mm4_pkg::DATA_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   mm4_req_if.sink  req_ch,
   mm4_rsp_if.source rsp_ch
);

   mm4_pkg::cmd_type    cmd;
   mm4_pkg::status_type status;

   mm4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_row   (req_ch.row),
      .req_col   (req_ch.col),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   mm4_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .wr_value      (req_ch.value),
      .status        (status),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_row       (rsp_ch.out_row),
      .rsp_col       (rsp_ch.out_col),
      .rsp_product   (rsp_ch.product),
      .rsp_saturated (rsp_ch.saturated),
      .rsp_last      (rsp_ch.last)
   );

endmodule
